@@ hw/rtl/brfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfc_pkg
// Shared widths and constants for the response frame checker.
// ----------------------------------------------------------------------------
package brfc_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 10;
	localparam int SUM_W  = 16;

	// longest burst the link is expected to deliver
	localparam int MAX_BURST_BYTES = 1023;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'hDD;
	localparam logic [LEN_W-1:0]  MIN_FRAME  = 10'd5;

	// frame length cap for the package's default MAX_BURST_BYTES
	localparam logic [LEN_W-1:0] LEN_CAP =
		(MAX_BURST_BYTES < 1023) ? LEN_W'(MAX_BURST_BYTES) : 10'd1023;

endpackage

@@ hw/rtl/brfc_rx_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfc_rx_if
// Byte stream channel: one received byte and its end-of-burst flag.
// ----------------------------------------------------------------------------
interface brfc_rx_if
	import brfc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              burst_end;

	modport source (output valid, output rx_byte, output burst_end, input ready);
	modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

@@ hw/rtl/brfc_verdict_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfc_verdict_if
// Verdict channel: one result per received burst.
// ----------------------------------------------------------------------------
interface brfc_verdict_if
	import brfc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             start_found;
	logic             checksum_ok;
	logic [LEN_W-1:0] frame_length;
	logic [SUM_W-1:0] received_checksum;
	logic [SUM_W-1:0] computed_checksum;

	modport source (
		output valid, output start_found, output checksum_ok, output frame_length,
		output received_checksum, output computed_checksum, input ready
	);
	modport sink (
		input valid, input start_found, input checksum_ok, input frame_length,
		input received_checksum, input computed_checksum, output ready
	);
endinterface

@@ hw/rtl/bms_response_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_response_frame_checker
// Locks on the first 0xDD of a burst, sums the frame body and checks it
// against the big-endian checksum carried in the frame's tail.
// ----------------------------------------------------------------------------
// Takes one byte per clock unless stalled and gives one verdict per burst,
// registered from the byte that carries burst_end. Each byte is first held in
// an input register; the frame state (lock, position, three-byte delay line,
// running sum) and the verdict register are updated from it together.
// The input side keeps taking bytes while a verdict waits, and stalls only
// when a second burst end would have to overwrite an untaken verdict.
// ----------------------------------------------------------------------------
module bms_response_frame_checker
	import brfc_pkg::*;
#(
	parameter int MAX_BURST_BYTES = brfc_pkg::MAX_BURST_BYTES
)
(
	input  logic           clk,
	input  logic           arst_n,
	brfc_rx_if.sink        rx,
	brfc_verdict_if.source verdict
);

	// frame length saturates here
	localparam logic [LEN_W-1:0] LEN_LIMIT =
		(MAX_BURST_BYTES < 1023) ? LEN_W'(MAX_BURST_BYTES) : 10'd1023;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// frame state
	logic              locked_q;
	logic [LEN_W-1:0]  pos_q;
	logic [BYTE_W-1:0] dly_q [3];
	logic [SUM_W-1:0]  sum_q;

	// verdict register
	logic             out_valid_q;
	logic             start_found_q;
	logic             checksum_ok_q;
	logic [LEN_W-1:0] frame_length_q;
	logic [SUM_W-1:0] received_q;
	logic [SUM_W-1:0] computed_q;

	logic              advance;
	logic              locked_nx;
	logic [LEN_W-1:0]  pos_nx;
	logic [BYTE_W-1:0] dly_nx [3];
	logic [SUM_W-1:0]  sum_nx;
	logic [SUM_W-1:0]  received;
	logic [SUM_W-1:0]  computed;

	// a non-final byte never needs the verdict register
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign rx.ready = !valid_s1 || advance;

	always_comb begin
		locked_nx = locked_q;
		pos_nx    = pos_q;
		dly_nx    = dly_q;
		sum_nx    = sum_q;
		received  = '0;
		if (locked_q) begin
			// byte three back leaves the delay line into the sum
			if (pos_q >= MIN_FRAME) begin
				sum_nx = sum_q + SUM_W'(dly_q[2]);
			end
			received  = {dly_q[1], dly_q[0]};
			dly_nx[2] = dly_q[1];
			dly_nx[1] = dly_q[0];
			dly_nx[0] = byte_s1;
			if (pos_q < LEN_LIMIT) begin
				pos_nx = pos_q + 1'b1;
			end
		end else if (byte_s1 == START_BYTE) begin
			locked_nx = 1'b1;
			pos_nx    = LEN_W'(1);
			dly_nx[0] = byte_s1;
		end
		computed = SUM_W'(0) - sum_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
			last_s1 <= rx.burst_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= 1'b0;
			pos_q    <= '0;
			dly_q    <= '{default: '0};
			sum_q    <= '0;
		end else if (advance) begin
			if (last_s1) begin
				locked_q <= 1'b0;
				pos_q    <= '0;
				dly_q    <= '{default: '0};
				sum_q    <= '0;
			end else begin
				locked_q <= locked_nx;
				pos_q    <= pos_nx;
				dly_q    <= dly_nx;
				sum_q    <= sum_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			start_found_q  <= locked_nx;
			checksum_ok_q  <= locked_nx && (pos_nx >= MIN_FRAME) && (computed == received);
			frame_length_q <= locked_nx ? pos_nx : '0;
			received_q     <= locked_nx ? received : '0;
			computed_q     <= locked_nx ? computed : '0;
		end
	end

	assign verdict.valid             = out_valid_q;
	assign verdict.start_found       = start_found_q;
	assign verdict.checksum_ok       = checksum_ok_q;
	assign verdict.frame_length      = frame_length_q;
	assign verdict.received_checksum = received_q;
	assign verdict.computed_checksum = computed_q;

endmodule
